FILE: design/assert_macros.svh
// Assertion macros for the checker of the matrix multiplier.
// Depends on nothing; included by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at each rising edge of clk while rst_n is high.
`define SMM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: design/smm_pkg.sv
// Shared constants for the Strassen matrix multiplier.
// Used by the interfaces and by every module of the block but the queue.
package smm_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned LgW   = 2;
  localparam int unsigned IdxW  = 3;
endpackage

FILE: design/smm_in_if.sv
// Input channel of the matrix multiplier: one A and B element pair per item.
// Depends on smm_pkg.
interface smm_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [smm_pkg::DataW-1:0] a_element;
  logic signed [smm_pkg::DataW-1:0] b_element;
  modport source (output valid, a_element, b_element, input ready);
  modport sink (input valid, a_element, b_element, output ready);
endinterface

FILE: design/smm_out_if.sv
// Output channel of the matrix multiplier: one product element per item.
// Depends on smm_pkg.
interface smm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [smm_pkg::DataW-1:0] c_element;
  logic [smm_pkg::IdxW-1:0]         row_index;
  logic [smm_pkg::IdxW-1:0]         col_index;
  logic                              last;
  modport source (output valid, c_element, row_index, col_index, last, input ready);
  modport sink (input valid, c_element, row_index, col_index, last, output ready);
endinterface

FILE: design/smm_cfg_if.sv
// Configuration write channel carrying the size_log2 register.
// Depends on smm_pkg.
interface smm_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [smm_pkg::LgW-1:0] size_log2;
  modport source (output valid, size_log2, input ready);
  modport sink (input valid, size_log2, output ready);
endinterface

FILE: design/smm_fifo.sv
// Two-entry queue between the loading front and the computing back.
// Depends on nothing.
module smm_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);
  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end
endmodule

FILE: design/smm_front.sv
// Loading front: holds size_log2, counts loaded pairs and queues store writes.
// Depends on smm_pkg.
module smm_front #(
  parameter int unsigned MaxDim = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [smm_pkg::LgW-1:0]      cfg_size_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [smm_pkg::DataW-1:0]    a_i,
  input  logic [smm_pkg::DataW-1:0]    b_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output logic [1+smm_pkg::LgW+2*$clog2(MaxDim)+2*smm_pkg::DataW-1:0] push_data_o
);
  localparam int unsigned LogW = $clog2(MaxDim);
  localparam int unsigned AddrW = 2 * LogW;

  logic [smm_pkg::LgW-1:0] size_q;
  logic [AddrW-1:0]        count_q;
  logic [smm_pkg::LgW-1:0] lg;
  logic [AddrW:0]          total, count_inc;
  logic                    is_last, accept;

  assign lg = (size_q > smm_pkg::LgW'(LogW)) ? smm_pkg::LgW'(LogW) : size_q;
  assign total = (AddrW+1)'(1) << (2 * lg);
  assign count_inc = {1'b0, count_q} + (AddrW+1)'(1);
  assign is_last = (count_inc == total);
  assign cfg_ready_o = 1'b1;
  assign in_ready_o = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept = in_valid_i && push_ready_i;
  assign push_data_o = {is_last, lg, count_q, a_i, b_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= smm_pkg::LgW'(3);
      count_q <= '0;
    end else if (cfg_valid_i) begin
      size_q  <= cfg_size_i;
      count_q <= '0;
    end else if (accept) begin
      count_q <= is_last ? '0 : count_inc[AddrW-1:0];
    end
  end
endmodule

FILE: design/smm_back.sv
// Computing back: owns the A and B stores and forms each product element as a
// dot product through one shared multiplier. Depends on smm_pkg.
module smm_back #(
  parameter int unsigned MaxDim = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  logic [1+smm_pkg::LgW+2*$clog2(MaxDim)+2*smm_pkg::DataW-1:0] pop_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [smm_pkg::DataW-1:0]    out_c_o,
  output logic [smm_pkg::IdxW-1:0]     out_row_o,
  output logic [smm_pkg::IdxW-1:0]     out_col_o,
  output logic                          out_last_o
);
  localparam int unsigned LogW = $clog2(MaxDim);
  localparam int unsigned AddrW = 2 * LogW;
  localparam int unsigned Depth = MaxDim * MaxDim;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StRun   = 3'b010,
    StDrain = 3'b100
  } state_e;

  logic [smm_pkg::DataW-1:0] a_mem [Depth];
  logic [smm_pkg::DataW-1:0] b_mem [Depth];

  state_e                    state_q;
  logic [smm_pkg::LgW-1:0]  lg_q;
  logic [LogW-1:0]           r_q, c_q, k_q, mask;
  logic                      rd_vld_q, prod_vld_q;
  logic [smm_pkg::DataW-1:0] a_rd_q, b_rd_q, prod_q, acc_q;
  logic                      e_last;
  logic [smm_pkg::LgW-1:0]  e_lg;
  logic [AddrW-1:0]          e_addr, a_addr, b_addr;
  logic [smm_pkg::DataW-1:0] e_a, e_b;
  logic                      issue, finish, last_elem;

  assign {e_last, e_lg, e_addr, e_a, e_b} = pop_data_i;
  assign pop_ready_o = (state_q == StIdle);
  assign mask = LogW'((1 << lg_q) - 1);
  assign a_addr = (AddrW'(r_q) << lg_q) | AddrW'(k_q);
  assign b_addr = (AddrW'(k_q) << lg_q) | AddrW'(c_q);
  assign issue = (state_q == StRun);
  assign finish = (state_q == StDrain) && !rd_vld_q && !prod_vld_q && !out_valid_o;
  assign last_elem = (r_q == mask) && (c_q == mask);

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      a_mem[e_addr] <= e_a;
      b_mem[e_addr] <= e_b;
    end
    a_rd_q <= a_mem[a_addr];
    b_rd_q <= b_mem[b_addr];
    prod_q <= smm_pkg::DataW'(a_rd_q * b_rd_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      lg_q        <= '0;
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      acc_q       <= '0;
      out_valid_o <= 1'b0;
      out_c_o     <= '0;
      out_row_o   <= '0;
      out_col_o   <= '0;
      out_last_o  <= 1'b0;
    end else begin
      rd_vld_q   <= issue;
      prod_vld_q <= rd_vld_q;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (prod_vld_q) acc_q <= acc_q + prod_q;
      unique case (state_q)
        StIdle: begin
          if (pop_valid_i && e_last) begin
            lg_q    <= e_lg;
            r_q     <= '0;
            c_q     <= '0;
            k_q     <= '0;
            acc_q   <= '0;
            state_q <= StRun;
          end
        end
        StRun: begin
          if (k_q == mask) begin
            k_q     <= '0;
            state_q <= StDrain;
          end else begin
            k_q <= k_q + LogW'(1);
          end
        end
        StDrain: begin
          if (finish) begin
            out_valid_o <= 1'b1;
            out_c_o     <= acc_q;
            out_row_o   <= smm_pkg::IdxW'(r_q);
            out_col_o   <= smm_pkg::IdxW'(c_q);
            out_last_o  <= last_elem;
            acc_q       <= '0;
            if (last_elem) begin
              state_q <= StIdle;
            end else begin
              if (c_q == mask) begin
                c_q <= '0;
                r_q <= r_q + LogW'(1);
              end else begin
                c_q <= c_q + LogW'(1);
              end
              state_q <= StRun;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

FILE: design/strassen_matrix_multiply.sv
// Square matrix multiplier for dimensions 1, 2, 4 or 8 (size_log2, clamped to MAX_DIM).
// Pairs of A and B elements are taken one per cycle while in_ch.ready is high, in
// row-major order; after the last pair every element of C = A * B, wrapped to 32 bits,
// comes out in row-major order with its row, column and a last flag. Each C element
// is a dot product through one shared 32-bit multiplier fed by registered store reads.
// The stores need no clearing after reset. Writing size_log2 drops a partly loaded
// matrix.
module strassen_matrix_multiply #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  smm_cfg_if.sink    cfg_ch,
  smm_in_if.sink     in_ch,
  smm_out_if.source  out_ch
);
  localparam int unsigned EntryW = 1 + smm_pkg::LgW + 2 * $clog2(MAX_DIM) + 2 * smm_pkg::DataW;

  logic              push_valid, push_ready, pop_valid, pop_ready;
  logic [EntryW-1:0] push_data, pop_data;
  logic [smm_pkg::DataW-1:0] c_raw;

  smm_front #(.MaxDim(MAX_DIM)) u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i (cfg_ch.valid),
    .cfg_ready_o (cfg_ch.ready),
    .cfg_size_i  (cfg_ch.size_log2),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .a_i         (in_ch.a_element),
    .b_i         (in_ch.b_element),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  smm_fifo #(.Width(EntryW)) u_fifo (
    .clk_i, .rst_ni,
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  smm_back #(.MaxDim(MAX_DIM)) u_back (
    .clk_i, .rst_ni,
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .out_valid_o(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .out_c_o    (c_raw),
    .out_row_o  (out_ch.row_index),
    .out_col_o  (out_ch.col_index),
    .out_last_o (out_ch.last)
  );

  assign out_ch.c_element = $signed(c_raw);
endmodule

FILE: design/smm_checker.sv
// Port-level checks for the matrix multiplier, bound to the top level.
// Depends on assert_macros.svh and smm_pkg.
`include "assert_macros.svh"

module smm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [smm_pkg::DataW-1:0]    out_c,
  input logic [smm_pkg::IdxW-1:0]     out_row,
  input logic [smm_pkg::IdxW-1:0]     out_col,
  input logic                          out_last
);
  `SMM_ASSERT(a_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid && $stable(out_c), "stalled item changed")
  `SMM_ASSERT(a_gap, clk_i, rst_ni, out_valid && out_ready |=> !out_valid, "items too close together")
  `SMM_ASSERT(a_last_diag, clk_i, rst_ni, out_valid && out_last |-> out_row == out_col, "last item off the diagonal")
endmodule

bind strassen_matrix_multiply smm_checker u_smm_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_c    (out_ch.c_element),
  .out_row  (out_ch.row_index),
  .out_col  (out_ch.col_index),
  .out_last (out_ch.last)
);

FILE: test/tb_smm_if.sv
// Testbench copies of the channel interfaces are not needed; this file holds
// a small helper package of testbench types. Depends on smm_pkg.
`timescale 1ns / 1ps
package tb_smm_types;
  typedef struct packed {
    logic signed [smm_pkg::DataW-1:0] c_element;
    logic [smm_pkg::IdxW-1:0]         row_index;
    logic [smm_pkg::IdxW-1:0]         col_index;
    logic                             last;
  } product_item_t;
endpackage

FILE: test/tb_strassen_matrix_multiply.sv
// Self-checking testbench for strassen_matrix_multiply: loads directed and random matrices at
// every size, predicts each product element and checks the emitted stream.
// Depends on smm_pkg, the channel interfaces and tb_smm_types.
`timescale 1ns / 1ps
module tb_strassen_matrix_multiply;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  smm_cfg_if cfg_ch ();
  smm_in_if  in_ch ();
  smm_out_if out_ch ();

  strassen_matrix_multiply #(.MAX_DIM(8)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  logic [1:0]    size_log2_q = 2'd3;
  logic [31:0]   a_mat [64];
  logic [31:0]   b_mat [64];
  int unsigned   pairs_loaded = 0;
  tb_smm_types::product_item_t product_queue[$];
  int unsigned   n_errors = 0;
  int unsigned   n_checked = 0;
  int unsigned   n_matrices = 0;
  longint unsigned cycles = 0;

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.size_log2 = '0;
    in_ch.valid = 1'b0;
    in_ch.a_element = '0;
    in_ch.b_element = '0;
    out_ch.ready = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    n_errors++;
  endtask

  // The low 32 bits of the ordinary product equal the Strassen result.
  task automatic predict_product();
    int unsigned dim;
    logic [31:0] acc;
    tb_smm_types::product_item_t it;
    dim = 1 << size_log2_q;
    for (int r = 0; r < dim; r++) begin
      for (int c = 0; c < dim; c++) begin
        acc = '0;
        for (int k = 0; k < dim; k++) acc += a_mat[r*dim+k] * b_mat[k*dim+c];
        it.c_element = acc;
        it.row_index = 3'(r);
        it.col_index = 3'(c);
        it.last = (r == dim - 1) && (c == dim - 1);
        product_queue.push_back(it);
      end
    end
    n_matrices++;
  endtask

  task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
    int unsigned gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.a_element <= a;
    in_ch.b_element <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    a_mat[pairs_loaded] = a;
    b_mat[pairs_loaded] = b;
    pairs_loaded++;
    if (pairs_loaded == (1 << (2 * size_log2_q))) begin
      pairs_loaded = 0;
      predict_product();
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (product_queue.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [1:0] lg);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.size_log2 <= lg;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    size_log2_q = lg;
    pairs_loaded = 0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_matrix(input int mode);
    int unsigned total;
    total = 1 << (2 * size_log2_q);
    for (int i = 0; i < total; i++) begin
      case (mode)
        0: send_pair(32'h8000_0000, 32'h8000_0000);
        1: send_pair(32'h7fff_ffff, 32'hffff_ffff);
        2: send_pair('0, '0);
        default: send_pair(rand_word(), rand_word());
      endcase
    end
  endtask

  task automatic test_directed();
    write_size(2'd0);
    send_matrix(0);
    send_matrix(1);
    write_size(2'd1);
    send_matrix(1);
    send_matrix(2);
    // A partly loaded matrix is dropped by a size write.
    send_pair(32'h1234_5678, 32'hdead_beef);
    write_size(2'd1);
    send_matrix(3);
    write_size(2'd2);
    send_matrix(0);
  endtask

  task automatic test_random();
    int unsigned sent;
    logic [1:0] lg;
    sent = 0;
    while (sent < 360) begin
      lg = 2'($urandom_range(0, 3));
      write_size(lg);
      repeat ($urandom_range(1, 3)) begin
        send_matrix(3);
        sent += 1 << (2 * lg);
      end
    end
    write_size(2'd3);
    send_matrix(3);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (product_queue.size() == 0) begin
        report_mismatch("product item with none expected");
      end else begin
        tb_smm_types::product_item_t exp_it;
        exp_it = product_queue.pop_front();
        n_checked++;
        if (out_ch.c_element !== exp_it.c_element)
          report_mismatch($sformatf("c_element %h, expected %h", out_ch.c_element,
                                    exp_it.c_element));
        if (out_ch.row_index !== exp_it.row_index) report_mismatch("row_index");
        if (out_ch.col_index !== exp_it.col_index) report_mismatch("col_index");
        if (out_ch.last !== exp_it.last) report_mismatch("last");
      end
    end
  end

  // Receiver stalls drawn per item, with quiet stretches between.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  initial begin
    wait (cycles == 64'd2_000_000);
    $display("timeout");
    $display("** strassen_matrix_multiply: FAILED **");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    drain();
    $display("Checked %0d product items from %0d matrices of all four sizes.",
             n_checked, n_matrices);
    if (n_errors == 0 && product_queue.size() == 0) begin
      $display("** strassen_matrix_multiply: PASSED **");
    end else begin
      $display("** strassen_matrix_multiply: FAILED **");
    end
    $finish;
  end
endmodule
